// ----- design/rcot_pkg.sv -----
// ----------------------------------------------------------------------------
// rcot_pkg: shared definitions for the shape overlap test
// Pair-kind command codes and the default coordinate width.
// ----------------------------------------------------------------------------
`default_nettype none

package rcot_pkg;

   // default coordinate width, signed Q12.4
   localparam int unsigned COORD_WIDTH_DEF = 16;

   // pair kind carried with each transaction
   typedef enum logic [1:0] {
      CMD_RECT_RECT     = 2'd0,
      CMD_CIRCLE_CIRCLE = 2'd1,
      CMD_RECT_CIRCLE   = 2'd2,
      CMD_CIRCLE_RECT   = 2'd3
   } command_type;

endpackage : rcot_pkg

`default_nettype wire

// ----- design/rect_circle_overlap_test.sv -----
// ----------------------------------------------------------------------------
// rect_circle_overlap_test: pipelined rect/circle collision test
// Overlap test for a pair of 2-D shapes (rect/rect, circle/circle, rect/circle).
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one shape pair per transaction: a command naming the
//   pair kind and four signed coordinates for each of shapes A and B.
//   rsp_ channel returns one transaction per request with the single bit hit.
//   Both channels use valid/ready; a transaction moves when both are high.
//   Throughput is one pair per cycle unless the output stalls: three register
//   stages (operand select and edge compares, squaring, square sums and final
//   compare) each hold one pair. When the receiver holds rsp_ready low while
//   the output stage is full, the whole pipeline freezes; req_ready drops
//   only then, and nothing is lost or repeated. A synchronous reset empties
//   all stages; results then resume with the next accepted request.
//   Squares are exact at full width, so no result saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module rect_circle_overlap_test #(
   parameter int unsigned COORD_WIDTH = rcot_pkg::COORD_WIDTH_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   // request channel
   input  wire                          req_valid,
   output logic                         req_ready,
   input  rcot_pkg::command_type        req_command,
   input  wire signed [COORD_WIDTH-1:0] req_a_left_or_cx,
   input  wire signed [COORD_WIDTH-1:0] req_a_top_or_cy,
   input  wire signed [COORD_WIDTH-1:0] req_a_right_or_radius,
   input  wire signed [COORD_WIDTH-1:0] req_a_bottom,
   input  wire signed [COORD_WIDTH-1:0] req_b_left_or_cx,
   input  wire signed [COORD_WIDTH-1:0] req_b_top_or_cy,
   input  wire signed [COORD_WIDTH-1:0] req_b_right_or_radius,
   input  wire signed [COORD_WIDTH-1:0] req_b_bottom,
   // response channel
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic                         rsp_hit
);

   import rcot_pkg::*;

   localparam int unsigned W   = COORD_WIDTH;
   localparam int unsigned SQW = 2 * W + 1;   // exact square of a W+1 bit value
   localparam int unsigned SMW = SQW + 1;     // sum of two squares

   // sign extend one coordinate by one bit
   function automatic logic signed [W:0] ext(input logic signed [W-1:0] v);
      return {v[W-1], v};
   endfunction

   // exact square of a W+1 bit signed value
   function automatic logic [SQW-1:0] square_fn(input logic signed [W:0] v);
      logic signed [2*W+1:0] p;
      p = v * v;
      return p[SQW-1:0];
   endfunction

   // pipeline advance: all stages move together unless the output is stuck
   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // ---------------------------------------------------------------------
   // stage 1: operand select, differences, edge compares
   // ---------------------------------------------------------------------
   logic              s1_valid_ff, s1_valid_in;
   command_type       s1_cmd_ff, s1_cmd_in;
   logic              s1_rect_hit_ff, s1_rect_hit_in;
   logic              s1_band_ff, s1_band_in;
   logic signed [W:0] s1_dx1_ff, s1_dx1_in;
   logic signed [W:0] s1_dx2_ff, s1_dx2_in;
   logic signed [W:0] s1_dy1_ff, s1_dy1_in;
   logic signed [W:0] s1_dy2_ff, s1_dy2_in;
   logic signed [W:0] s1_r_ff, s1_r_in;

   logic signed [W:0] x1, y1, x2, y2, xc, yc, rad;

   // box and circle operands, swapped for circle A / rect B
   always_comb begin
      s1_valid_in = req_valid;
      s1_cmd_in   = req_command;
      if (req_command == CMD_CIRCLE_RECT) begin
         x1  = ext(req_b_left_or_cx);
         y1  = ext(req_b_top_or_cy);
         x2  = ext(req_b_right_or_radius);
         y2  = ext(req_b_bottom);
         xc  = ext(req_a_left_or_cx);
         yc  = ext(req_a_top_or_cy);
         rad = ext(req_a_right_or_radius);
      end else begin
         x1  = ext(req_a_left_or_cx);
         y1  = ext(req_a_top_or_cy);
         x2  = ext(req_a_right_or_radius);
         y2  = ext(req_a_bottom);
         xc  = ext(req_b_left_or_cx);
         yc  = ext(req_b_top_or_cy);
         rad = ext(req_b_right_or_radius);
      end

      // rect/rect: touching edges count
      s1_rect_hit_in = !(req_a_right_or_radius < req_b_left_or_cx ||
                         req_a_left_or_cx > req_b_right_or_radius ||
                         req_a_bottom < req_b_top_or_cy ||
                         req_a_top_or_cy > req_b_bottom);

      // center inside the box widened by r along y or along x, strict bounds
      s1_band_in = (xc > x1 && xc < x2 && yc > y1 - rad && yc < y2 + rad) ||
                   (xc > x1 - rad && xc < x2 + rad && yc > y1 && yc < y2);

      // corner offsets; dx1/dy1 double as the center offset for circle/circle
      s1_dx1_in = x1 - xc;
      s1_dx2_in = x2 - xc;
      s1_dy1_in = y1 - yc;
      s1_dy2_in = y2 - yc;

      // radius, or radius sum for circle/circle
      if (req_command == CMD_CIRCLE_CIRCLE) begin
         s1_r_in = ext(req_a_right_or_radius) + ext(req_b_right_or_radius);
      end else begin
         s1_r_in = rad;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cmd_ff      <= s1_cmd_in;
         s1_rect_hit_ff <= s1_rect_hit_in;
         s1_band_ff     <= s1_band_in;
         s1_dx1_ff      <= s1_dx1_in;
         s1_dx2_ff      <= s1_dx2_in;
         s1_dy1_ff      <= s1_dy1_in;
         s1_dy2_ff      <= s1_dy2_in;
         s1_r_ff        <= s1_r_in;
      end
   end

   // ---------------------------------------------------------------------
   // stage 2: squares
   // ---------------------------------------------------------------------
   logic            s2_valid_ff;
   command_type     s2_cmd_ff;
   logic            s2_rect_hit_ff;
   logic            s2_band_ff;
   logic [SQW-1:0]  s2_sx1_ff, s2_sx1_in;
   logic [SQW-1:0]  s2_sx2_ff, s2_sx2_in;
   logic [SQW-1:0]  s2_sy1_ff, s2_sy1_in;
   logic [SQW-1:0]  s2_sy2_ff, s2_sy2_in;
   logic [SQW-1:0]  s2_rr_ff, s2_rr_in;

   always_comb begin
      s2_sx1_in = square_fn(s1_dx1_ff);
      s2_sx2_in = square_fn(s1_dx2_ff);
      s2_sy1_in = square_fn(s1_dy1_ff);
      s2_sy2_in = square_fn(s1_dy2_ff);
      s2_rr_in  = square_fn(s1_r_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_cmd_ff      <= s1_cmd_ff;
         s2_rect_hit_ff <= s1_rect_hit_ff;
         s2_band_ff     <= s1_band_ff;
         s2_sx1_ff      <= s2_sx1_in;
         s2_sx2_ff      <= s2_sx2_in;
         s2_sy1_ff      <= s2_sy1_in;
         s2_sy2_ff      <= s2_sy2_in;
         s2_rr_ff       <= s2_rr_in;
      end
   end

   // ---------------------------------------------------------------------
   // stage 3: corner distances against r squared, final select
   // ---------------------------------------------------------------------
   logic           s3_valid_ff;
   logic           s3_hit_ff, s3_hit_in;
   logic [SMW-1:0] d11, d21, d22, d12, rr_ext;
   logic           corner_hit;

   always_comb begin
      d11    = {1'b0, s2_sx1_ff} + {1'b0, s2_sy1_ff};
      d21    = {1'b0, s2_sx2_ff} + {1'b0, s2_sy1_ff};
      d22    = {1'b0, s2_sx2_ff} + {1'b0, s2_sy2_ff};
      d12    = {1'b0, s2_sx1_ff} + {1'b0, s2_sy2_ff};
      rr_ext = {1'b0, s2_rr_ff};

      // any box corner strictly inside the circle
      corner_hit = (d11 < rr_ext) || (d21 < rr_ext) || (d22 < rr_ext) || (d12 < rr_ext);

      case (s2_cmd_ff)
         CMD_RECT_RECT:     s3_hit_in = s2_rect_hit_ff;
         CMD_CIRCLE_CIRCLE: s3_hit_in = (d11 <= rr_ext);
         CMD_RECT_CIRCLE,
         CMD_CIRCLE_RECT:   s3_hit_in = s2_band_ff || corner_hit;
         default:           s3_hit_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_hit_ff <= s3_hit_in;
      end
   end

   // response transaction
   assign rsp_valid = s3_valid_ff;
   assign rsp_hit   = s3_hit_ff;

endmodule : rect_circle_overlap_test

`default_nettype wire
